>>> src/sobnms_pkg.sv
// Shared types, constants and tap tables for the Sobel non-maximum suppression core.
package sobnms_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;
  localparam int unsigned RingRows     = 8;
  localparam int unsigned RingBits     = 3;
  localparam int unsigned CfgW         = 11;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned PixW         = 8;
  localparam int unsigned MagW         = 11;
  localparam int unsigned GradW        = 11;
  localparam int unsigned AbsW         = 10;
  localparam int unsigned SqW          = 20;
  localparam int unsigned EnergyW      = 21;
  localparam int unsigned TanSteepQ8   = 618;
  localparam int unsigned TanFlatQ8    = 106;

  localparam logic [CfgW-1:0]    FrameWidthRst  = 11'd640;
  localparam logic [CfgW-1:0]    FrameHeightRst = 11'd480;
  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;
  localparam logic               KindPixel      = 1'b0;
  localparam logic               KindFlush      = 1'b1;

  typedef enum logic [1:0] {SectVert, SectRise, SectHorz, SectFall} sect_e;
  typedef enum logic [1:0] {PosCenter, PosN1, PosN2} pos_e;
  typedef enum logic [3:0] {
    StIdle, StCheck, StCen, StSect, StN1Go, StN1, StN2Go, StN2, StSqGo, StSq, StOut
  } state_e;

  typedef struct packed {
    logic take;
    logic en_start;
    pos_e pos;
    logic latch_center;
    logic latch_sector;
    logic cmp_n1;
    logic cmp_n2;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic due;
    logic en_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

  // tap t = 3*row + col of the 3x3 window
  function automatic logic [1:0] tap_row(input logic [3:0] t);
    logic [1:0] r;
    case (t)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tap_col(input logic [3:0] t);
    logic [1:0] c;
    case (t)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic signed [2:0] gx_coef(input logic [3:0] t);
    logic signed [2:0] k;
    case (t)
      4'd0, 4'd6: k = -3'sd1;
      4'd2, 4'd8: k = 3'sd1;
      4'd3:       k = -3'sd2;
      4'd5:       k = 3'sd2;
      default:    k = 3'sd0;
    endcase
    return k;
  endfunction

  function automatic logic signed [2:0] gy_coef(input logic [3:0] t);
    logic signed [2:0] k;
    case (t)
      4'd0, 4'd2: k = -3'sd1;
      4'd6, 4'd8: k = 3'sd1;
      4'd1:       k = -3'sd2;
      4'd7:       k = 3'sd2;
      default:    k = 3'sd0;
    endcase
    return k;
  endfunction

endpackage

>>> src/sobnms_isqrt.sv
// Iterative floor square root, built up bit by bit; a new start abandons any root in progress.
module sobnms_isqrt import sobnms_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [EnergyW-1:0] value_i,
  output logic               done_o,
  output logic [MagW-1:0]    root_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [EnergyW-1:0] v_q, v_d, res_q, res_d, bit_q, bit_d, orig_q, orig_d, trial;

  assign trial = res_q + bit_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    orig_d = orig_q;
    if (start_i) begin
      busy_d = 1'b1;
      v_d    = value_i;
      orig_d = value_i;
      res_d  = '0;
      bit_d  = EnergyW'(1) << (EnergyW - 1);
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q == EnergyW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    orig_q <= orig_d;
  end

  assign done_o = done_q;
  assign root_o = MagW'(res_q);

`ifndef NO_ASSERTIONS
  a_root_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((22'(root_o) * 22'(root_o) <= 22'(orig_q)) &&
                ((22'(root_o) + 22'd1) * (22'(root_o) + 22'd1) > 22'(orig_q))))
    else $error("square root result out of range");
`endif

endmodule

>>> src/sobnms_ctrl.sv
// Sequencing state machine: input take, Sobel passes, compares, root and output load.
module sobnms_ctrl import sobnms_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StCheck;
      StCheck: state_d = status_i.due ? StCen : StIdle;
      StCen:   if (status_i.en_done) state_d = StSect;
      StSect:  state_d = StN1Go;
      StN1Go:  state_d = StN1;
      StN1:    if (status_i.en_done) state_d = StN2Go;
      StN2Go:  state_d = StN2;
      StN2:    if (status_i.en_done) state_d = StSqGo;
      StSqGo:  state_d = StSq;
      StSq:    if (status_i.sqrt_done) state_d = StOut;
      StOut:   if (status_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.pos  = PosCenter;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      StCheck: cmd_o.en_start = status_i.due;
      StCen:   cmd_o.latch_center = status_i.en_done;
      StSect:  cmd_o.latch_sector = 1'b1;
      StN1Go: begin
        cmd_o.en_start = 1'b1;
        cmd_o.pos      = PosN1;
      end
      StN1:    cmd_o.cmp_n1 = status_i.en_done;
      StN2Go: begin
        cmd_o.en_start = 1'b1;
        cmd_o.pos      = PosN2;
      end
      StN2:    cmd_o.cmp_n2 = status_i.en_done;
      StSqGo:  cmd_o.sqrt_start = 1'b1;
      StOut:   cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/sobnms_datapath.sv
// Pixel line memory, position counters, Sobel energy unit, sector logic and output register.
module sobnms_datapath import sobnms_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic                kind_i,
  input  logic [PixW-1:0]     pixel_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [MagW-1:0]     out_mag_o,
  output logic                out_row_end_o,
  output logic                out_frame_end_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int unsigned AW    = RingBits + CW;
  localparam int unsigned Depth = RingRows * (2 ** CW);

  logic [CfgW-1:0] fw_q, fw_d, fh_q, fh_d;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;

  always_comb begin
    if (32'(fw_q) < 32'd3)            w_eff = WW'(3);
    else if (32'(fw_q) > MAX_WIDTH)   w_eff = WW'(MAX_WIDTH);
    else                              w_eff = WW'(fw_q);
    if (32'(fh_q) < 32'd3)            h_eff = HW'(3);
    else if (32'(fh_q) > MAX_HEIGHT)  h_eff = HW'(MAX_HEIGHT);
    else                              h_eff = HW'(fh_q);
  end

  // input / output positions
  logic [CW-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic [LW-1:0] lead_q, lead_d;
  logic          in_full_q, in_full_d;
  logic          wr_en, restart, last_col, frame_end, cfg_hit;
  logic [LW:0]   thr;

  assign wr_en     = cmd_i.take && (kind_i == KindPixel) && !in_full_q;
  assign last_col  = (WW'(out_col_q) == w_eff - WW'(1));
  assign frame_end = last_col && (HW'(out_row_q) == h_eff - HW'(1));
  assign cfg_hit   = cfg_we_i && (cfg_index_i inside {RegFrameWidth, RegFrameHeight});
  assign restart   = cfg_hit || (cmd_i.out_load && frame_end);
  assign thr       = (LW + 1)'({w_eff, 1'b0}) + (LW + 1)'(3);

  always_comb begin
    fw_d      = fw_q;
    fh_d      = fh_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lead_d    = lead_q;
    in_full_d = in_full_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        RegFrameWidth:  fw_d = cfg_data_i;
        RegFrameHeight: fh_d = cfg_data_i;
        default: ;
      endcase
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lead_d    = '0;
      in_full_d = 1'b0;
    end else begin
      if (wr_en) begin
        lead_d = lead_q + LW'(1);
        if (WW'(in_col_q) == w_eff - WW'(1)) begin
          in_col_d = '0;
          if (HW'(in_row_q) == h_eff - HW'(1)) in_full_d = 1'b1;
          else                                 in_row_d  = in_row_q + RW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
      end
      if (cmd_i.out_load) begin
        lead_d = lead_q - LW'(1);
        if (last_col) begin
          out_col_d = '0;
          out_row_d = out_row_q + RW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
  end

  // pixel line memory, ring of rows
  logic [PixW-1:0] mem [Depth];
  logic [PixW-1:0] rdata_q;
  logic [AW-1:0]   waddr, raddr;

  assign waddr = {RingBits'(in_row_q), in_col_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= pixel_i;
    rdata_q <= mem[raddr];
  end

  // neighbour positions
  sect_e         sector_q, sector_d;
  logic [RW-1:0] ru, rd, sel_r;
  logic [CW-1:0] cpl, cmi, sel_c;
  logic          right, left, n1_valid, n2_valid;

  assign ru    = (out_row_q == '0) ? out_row_q : out_row_q - RW'(1);
  assign rd    = (HW'(out_row_q) + HW'(1) < h_eff) ? out_row_q + RW'(1) : out_row_q;
  assign cpl   = out_col_q + CW'(1);
  assign cmi   = out_col_q - CW'(1);
  assign right = (WW'(out_col_q) + WW'(1) < w_eff);
  assign left  = (out_col_q != '0);

  always_comb begin
    sel_r    = out_row_q;
    sel_c    = out_col_q;
    n1_valid = 1'b1;
    n2_valid = 1'b1;
    case (sector_q)
      SectVert: ;
      SectRise: begin
        n1_valid = right;
        n2_valid = left;
      end
      SectHorz: begin
        n1_valid = right;
        n2_valid = left;
      end
      default: begin
        n1_valid = left;
        n2_valid = right;
      end
    endcase
    case (cmd_i.pos)
      PosN1: begin
        case (sector_q)
          SectVert: sel_r = ru;
          SectRise: begin
            sel_r = ru;
            sel_c = cpl;
          end
          SectHorz: sel_c = cpl;
          default: begin
            sel_r = ru;
            sel_c = cmi;
          end
        endcase
      end
      PosN2: begin
        case (sector_q)
          SectVert: sel_r = rd;
          SectRise: begin
            sel_r = rd;
            sel_c = cmi;
          end
          SectHorz: sel_c = cmi;
          default: begin
            sel_r = rd;
            sel_c = cpl;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Sobel energy unit: nine taps read one per cycle, then square, then sum
  logic                    busy_q, busy_d, acc_en_q, en_done_q, en_done_d;
  logic [3:0]              step_q, step_d, tap_q;
  logic [RW-1:0]           er_q, er_d, rm, rp, tr;
  logic [CW-1:0]           ec_q, ec_d, cm, cp, tc;
  logic signed [GradW-1:0] gx_q, gx_d, gy_q, gy_d, pix_s, kx, ky;
  logic [AbsW-1:0]         agx, agy;
  logic [SqW-1:0]          sqx_q, sqy_q;
  logic [EnergyW-1:0]      energy_q;

  assign rm = (er_q == '0) ? RW'(1) : er_q - RW'(1);
  assign rp = (HW'(er_q) + HW'(1) < h_eff) ? er_q + RW'(1) : RW'(h_eff - HW'(2));
  assign cm = (ec_q == '0) ? CW'(1) : ec_q - CW'(1);
  assign cp = (WW'(ec_q) + WW'(1) < w_eff) ? ec_q + CW'(1) : CW'(w_eff - WW'(2));

  always_comb begin
    case (tap_row(step_q))
      2'd0:    tr = rm;
      2'd1:    tr = er_q;
      default: tr = rp;
    endcase
    case (tap_col(step_q))
      2'd0:    tc = cm;
      2'd1:    tc = ec_q;
      default: tc = cp;
    endcase
  end

  assign raddr = {RingBits'(tr), tc};
  assign pix_s = GradW'($signed({1'b0, rdata_q}));
  assign kx    = GradW'(gx_coef(tap_q));
  assign ky    = GradW'(gy_coef(tap_q));
  assign agx   = AbsW'(gx_q[GradW-1] ? -gx_q : gx_q);
  assign agy   = AbsW'(gy_q[GradW-1] ? -gy_q : gy_q);

  always_comb begin
    busy_d    = busy_q;
    step_d    = step_q;
    er_d      = er_q;
    ec_d      = ec_q;
    gx_d      = gx_q;
    gy_d      = gy_q;
    en_done_d = 1'b0;
    if (cmd_i.en_start) begin
      busy_d = 1'b1;
      step_d = '0;
      er_d   = sel_r;
      ec_d   = sel_c;
      gx_d   = '0;
      gy_d   = '0;
    end else if (busy_q) begin
      step_d = step_q + 4'd1;
      if (acc_en_q) begin
        gx_d = gx_q + kx * pix_s;
        gy_d = gy_q + ky * pix_s;
      end
      if (step_q == 4'd11) begin
        busy_d    = 1'b0;
        en_done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    er_q  <= er_d;
    ec_q  <= ec_d;
    gx_q  <= gx_d;
    gy_q  <= gy_d;
    tap_q <= step_q;
    sqx_q <= SqW'(agx) * SqW'(agx);
    sqy_q <= SqW'(agy) * SqW'(agy);
    if (busy_q && step_q == 4'd11) energy_q <= EnergyW'(sqx_q) + EnergyW'(sqy_q);
  end

  // centre values, sector and suppression
  logic signed [GradW-1:0] cgx_q, cgy_q, gys;
  logic [AbsW-1:0]         cax, cay;
  logic [EnergyW-1:0]      e0_q;
  logic                    sup_q, sup_d;
  logic signed [21:0]      lhs, flat;

  assign cax  = AbsW'(cgx_q[GradW-1] ? -cgx_q : cgx_q);
  assign cay  = AbsW'(cgy_q[GradW-1] ? -cgy_q : cgy_q);
  assign gys  = cgx_q[GradW-1] ? -cgy_q : cgy_q;
  assign lhs  = 22'(gys) * 22'sd256;
  assign flat = $signed(22'(cax)) * 22'sd106;

  always_comb begin
    if (cgx_q == '0)
      sector_d = SectVert;
    else if ((20'(cay) << 8) > 20'(cax) * 20'(TanSteepQ8))
      sector_d = SectVert;
    else if (lhs > flat)
      sector_d = SectRise;
    else if (lhs > -flat)
      sector_d = SectHorz;
    else
      sector_d = SectFall;
  end

  always_comb begin
    sup_d = sup_q;
    if (cmd_i.latch_center) sup_d = 1'b0;
    if (cmd_i.cmp_n1 && n1_valid && (e0_q < energy_q)) sup_d = 1'b1;
    if (cmd_i.cmp_n2 && n2_valid && (e0_q < energy_q)) sup_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    sup_q <= sup_d;
    if (cmd_i.latch_center) begin
      e0_q  <= energy_q;
      cgx_q <= gx_q;
      cgy_q <= gy_q;
    end
    if (cmd_i.latch_sector) sector_q <= sector_d;
  end

  // square root unit
  logic            sqrt_done;
  logic [MagW-1:0] root;

  sobnms_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .value_i (e0_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  logic [MagW-1:0] root_q;
  always_ff @(posedge clk_i) begin
    if (sqrt_done) root_q <= root;
  end

  // output register
  logic            ov_q, ov_d, orow_q, ofrm_q;
  logic [MagW-1:0] omag_q;

  assign ov_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : ov_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      omag_q <= sup_q ? '0 : root_q;
      orow_q <= !right;
      ofrm_q <= frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= FrameWidthRst;
      fh_q      <= FrameHeightRst;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lead_q    <= '0;
      in_full_q <= 1'b0;
      busy_q    <= 1'b0;
      step_q    <= '0;
      acc_en_q  <= 1'b0;
      en_done_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      fw_q      <= fw_d;
      fh_q      <= fh_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lead_q    <= lead_d;
      in_full_q <= in_full_d;
      busy_q    <= busy_d;
      step_q    <= step_d;
      acc_en_q  <= busy_q && (step_q < 4'd9);
      en_done_q <= en_done_d;
      ov_q      <= ov_d;
    end
  end

  assign status_o.due       = in_full_q || ({1'b0, lead_q} >= thr);
  assign status_o.en_done   = en_done_q;
  assign status_o.sqrt_done = sqrt_done;
  assign status_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o     = ov_q;
  assign out_mag_o       = omag_q;
  assign out_row_end_o   = orow_q;
  assign out_frame_end_o = ofrm_q;

`ifndef NO_ASSERTIONS
  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(in_col_q) < w_eff)
    else $error("input column beyond row width");
  a_out_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(out_col_q) < w_eff)
    else $error("output column beyond row width");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.en_start |-> !busy_q)
    else $error("energy pass started while busy");
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && frame_end) |=> (lead_q == '0 && !in_full_q))
    else $error("frame end did not restart positions");
`endif

endmodule

>>> src/sobel_gradient_nonmax_suppression_core.sv
// Top level of the Sobel gradient magnitude core with non-maximum suppression.
// Grey pixels enter in raster order. An accepted transaction that releases a result runs
// three Sobel passes (centre and two neighbours along the gradient sector), each reading
// the nine taps one per cycle from the dual-port pixel line memory, then an eleven-step
// square root, and waits while the output register is held by m_axis_tready; no new
// input is accepted meanwhile. Results trail the input by 2*W+2 pixels; flush
// transactions (tuser high) drain the tail of a frame.
// A write to either frame size register restarts the frame.
module sobel_gradient_nonmax_suppression_core import sobnms_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] pixel
  input  logic               s_axis_tuser,   // [0] kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,   // [10:0] magnitude, [15:11] zero
  output logic               m_axis_tlast,   // row_end
  output logic               m_axis_tuser,   // [0] frame_end
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cmd_t            cmd;
  status_t         status;
  logic [MagW-1:0] mag;

  assign cfg_ready_o = 1'b1;

  sobnms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sobnms_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_i          (s_axis_tuser),
    .pixel_i         (s_axis_tdata),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .out_mag_o       (mag),
    .out_row_end_o   (m_axis_tlast),
    .out_frame_end_o (m_axis_tuser)
  );

  assign m_axis_tdata = {5'b0, mag};

endmodule
